@@ src/box_table_point_lookup_core_defines.svh @@
// ----------------------------------------------------------------------------
// box table point lookup assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BOX_TABLE_POINT_LOOKUP_CORE_DEFINES_SVH
`define BOX_TABLE_POINT_LOOKUP_CORE_DEFINES_SVH

// consequent holds in the cycle after the antecedent
`define BTPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// consequent holds in the same cycle
`define BTPL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ src/btpl_pkg.sv @@
// ----------------------------------------------------------------------------
// btpl_pkg
// types and constants of the box table point lookup
// ----------------------------------------------------------------------------
package btpl_pkg;

  localparam int MaxBoxes = 1024;
  localparam int IdxW     = $clog2(MaxBoxes);
  localparam int CntW     = $clog2(MaxBoxes + 1);
  localparam int CoordW   = 24;
  localparam int DiagW    = 52;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // item passed from front to back
  typedef struct packed {
    logic [1:0]               cmd;
    logic [15:0]              box_id;
    logic [7:0]               box_level;
    logic                     box_ok;
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
  } btpl_item_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [15:0]     hit_id;
    logic [CntW-1:0] hit_count;
  } btpl_result_t;

endpackage

@@ src/btpl_front.sv @@
// ----------------------------------------------------------------------------
// btpl_front
// two-entry queue toward the back end
// ----------------------------------------------------------------------------
module btpl_front import btpl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  btpl_item_t in_item,
  output logic       q_valid,
  input  logic       q_take,
  output btpl_item_t q_item
);

  btpl_item_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_take;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ src/btpl_back.sv @@
// ----------------------------------------------------------------------------
// btpl_back
// box table memory, append path and the one-entry-per-cycle query scan
// ----------------------------------------------------------------------------
module btpl_back import btpl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [22:0]  margin,
  input  logic         q_valid,
  output logic         q_take,
  input  btpl_item_t   q_item,
  output logic         res_valid,
  input  logic         res_stall,
  output btpl_result_t res
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SQ   = 6'b000010,
    S_DIAG = 6'b000100,
    S_SCAN = 6'b001000,
    S_LAST = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam int RowW = 16 + 8 + 6 * CoordW + DiagW;

  logic [RowW-1:0] mem [MaxBoxes];
  logic [RowW-1:0] rd_row;

  state_t           state;
  logic [CntW-1:0]  entry_count;
  btpl_item_t       cur;
  logic [IdxW-1:0]  rd_addr;
  logic [CntW-1:0]  issued;
  logic             rd_live;
  logic             cmp_live;
  logic [CntW-1:0]  hit_count;
  logic             found;
  logic [7:0]       top_level;
  logic [DiagW-1:0] top_diag;
  logic [15:0]      best_id;
  logic [49:0]      sq [3];
  logic [DiagW-1:0] diag;

  // decoded stored row
  logic [15:0]              r_id;
  logic [7:0]               r_level;
  logic signed [CoordW-1:0] r_lo [3];
  logic signed [CoordW-1:0] r_hi [3];
  logic [DiagW-1:0]         r_diag;
  logic signed [CoordW-1:0] pt [3];
  logic                     contained;
  logic                     better;
  logic signed [CoordW+1:0] d_ax [3];

  assign {r_id, r_level, r_lo[0], r_lo[1], r_lo[2], r_hi[0], r_hi[1], r_hi[2], r_diag} = rd_row;
  assign pt[0] = cur.ax;
  assign pt[1] = cur.ay;
  assign pt[2] = cur.az;

  // margin compare, 26 bits is wide enough without wrap
  always_comb begin
    contained = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if ($signed({{2{pt[a][CoordW-1]}}, pt[a]}) <
          $signed({{2{r_lo[a][CoordW-1]}}, r_lo[a]}) - $signed({3'b000, margin}))
        contained = 1'b0;
      if ($signed({{2{pt[a][CoordW-1]}}, pt[a]}) >
          $signed({{2{r_hi[a][CoordW-1]}}, r_hi[a]}) + $signed({3'b000, margin}))
        contained = 1'b0;
    end
    better = !found || (r_level > top_level) ||
             (r_level == top_level && r_diag < top_diag) ||
             (r_level == top_level && r_diag == top_diag && r_id < best_id);
  end

  // signed extents of the appended box
  always_comb begin
    d_ax[0] = $signed({{2{cur.bx[CoordW-1]}}, cur.bx}) - $signed({{2{cur.ax[CoordW-1]}}, cur.ax});
    d_ax[1] = $signed({{2{cur.by[CoordW-1]}}, cur.by}) - $signed({{2{cur.ay[CoordW-1]}}, cur.ay});
    d_ax[2] = $signed({{2{cur.bz[CoordW-1]}}, cur.bz}) - $signed({{2{cur.az[CoordW-1]}}, cur.az});
  end

  assign diag = {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};

  assign q_take    = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (state == S_DIAG && cur.box_ok && entry_count < CntW'(MaxBoxes)) begin
      mem[entry_count[IdxW-1:0]] <= {cur.box_id, cur.box_level, cur.ax, cur.ay, cur.az,
                                     cur.bx, cur.by, cur.bz, diag};
    end
    rd_row <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      cur <= q_item;
    end
    // squares registered before the sum
    for (int a = 0; a < 3; a++) begin
      sq[a] <= 50'($signed(d_ax[a]) * $signed(d_ax[a]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rd_addr     <= '0;
      issued      <= '0;
      rd_live     <= 1'b0;
      cmp_live    <= 1'b0;
      hit_count   <= '0;
      found       <= 1'b0;
      top_level   <= '0;
      top_diag    <= '0;
      best_id     <= '0;
      res         <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            res       <= '0;
            hit_count <= '0;
            found     <= 1'b0;
            rd_addr   <= '0;
            issued    <= '0;
            rd_live   <= 1'b0;
            cmp_live  <= 1'b0;
            unique case (q_item.cmd)
              CMD_CLEAR: begin
                entry_count <= '0;
                state       <= S_OUT;
              end
              CMD_APPEND: state <= S_SQ;
              CMD_QUERY:  state <= S_SCAN;
              default:    state <= S_OUT;
            endcase
          end
        end
        S_SQ: begin
          // squares of the new item settle into sq
          state <= S_DIAG;
        end
        S_DIAG: begin
          if (!cur.box_ok) begin
            res.status <= ST_REJECT;
          end else if (entry_count >= CntW'(MaxBoxes)) begin
            res.status <= ST_FULL;
          end else begin
            entry_count <= entry_count + 1'b1;
          end
          state <= S_OUT;
        end
        S_SCAN: begin
          // read issue, read data, compare: the scan pipe
          rd_live  <= (issued < entry_count);
          cmp_live <= rd_live;
          if (issued < entry_count) begin
            issued  <= issued + 1'b1;
            rd_addr <= rd_addr + 1'b1;
          end
          if (rd_live && contained) begin
            hit_count <= hit_count + 1'b1;
            if (better) begin
              found     <= 1'b1;
              top_level <= r_level;
              top_diag  <= r_diag;
              best_id   <= r_id;
            end
          end
          if (!(issued < entry_count) && !rd_live && !cmp_live) state <= S_LAST;
        end
        S_LAST: begin
          res.hit_count <= hit_count;
          res.hit_id    <= found ? best_id : 16'd0;
          res.status    <= found ? ST_DONE : ST_MISS;
          state         <= S_OUT;
        end
        S_OUT: begin
          if (!res_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/box_table_point_lookup_core.sv @@
// ----------------------------------------------------------------------------
// box_table_point_lookup_core
// table of axis-aligned boxes with brute-force point containment lookup
// ----------------------------------------------------------------------------
// channel  | valid     | stall     | payload
// input    | in_valid  | in_stall  | cmd box_id box_level box_ok ax ay az bx by bz
// output   | out_valid | out_stall | status hit_id hit_count
//
// a query scans the whole table: the back end reads one stored box a cycle
//   from its table memory, which has one read and one write port, and compares it
// clear and the unused command go straight to the result register; append registers
//   the squared extents after the multipliers, then sums and writes the diagonal
// the back end returns to its idle state after each result before it takes the next item
// rst is synchronous; the table memory is not cleared, entry_count is
// a two-item queue lets the front take items while the back end scans
// ----------------------------------------------------------------------------
module box_table_point_lookup_core import btpl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [22:0]              cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic [15:0]              box_id,
  input  logic [7:0]               box_level,
  input  logic                     box_ok,
  input  logic signed [CoordW-1:0] ax,
  input  logic signed [CoordW-1:0] ay,
  input  logic signed [CoordW-1:0] az,
  input  logic signed [CoordW-1:0] bx,
  input  logic signed [CoordW-1:0] by,
  input  logic signed [CoordW-1:0] bz,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [15:0]              hit_id,
  output logic [CntW-1:0]          hit_count
);

  logic [22:0]  contain_margin;
  btpl_item_t   in_item;
  btpl_item_t   q_item;
  logic         q_valid;
  logic         q_take;
  btpl_result_t res;

  // margin register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      contain_margin <= '0;
    end else if (cfg_we) begin
      contain_margin <= cfg_wdata;
    end
  end

  assign in_item = '{cmd: cmd, box_id: box_id, box_level: box_level, box_ok: box_ok,
                     ax: ax, ay: ay, az: az, bx: bx, by: by, bz: bz};

  btpl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_take   (q_take),
    .q_item   (q_item)
  );

  btpl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .margin    (contain_margin),
    .q_valid   (q_valid),
    .q_take    (q_take),
    .q_item    (q_item),
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res       (res)
  );

  // result register drives the ports directly
  assign status    = res.status;
  assign hit_id    = res.hit_id;
  assign hit_count = res.hit_count;

endmodule

@@ src/btpl_checker.sv @@
// ----------------------------------------------------------------------------
// btpl_checker
// port-level checks of the box table point lookup
// ----------------------------------------------------------------------------
`include "box_table_point_lookup_core_defines.svh"

module btpl_checker import btpl_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input logic [1:0]      status,
  input logic [15:0]     hit_id,
  input logic [CntW-1:0] hit_count
);

  `BTPL_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status))
  `BTPL_ASSERT_NOW(a_miss_zero, clk, rst, out_valid && status == ST_MISS,
                   hit_id == 16'd0 && hit_count == '0)
  `BTPL_ASSERT_NOW(a_count_range, clk, rst, out_valid, hit_count <= CntW'(MaxBoxes))
  `BTPL_ASSERT_NOW(a_reject_zero, clk, rst, out_valid && (status == ST_REJECT ||
                   status == ST_FULL), hit_id == 16'd0 && hit_count == '0)

endmodule

bind box_table_point_lookup_core btpl_checker u_btpl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .hit_id    (hit_id),
  .hit_count (hit_count)
);

@@ test/tb_box_table_point_lookup_core.sv @@
// ----------------------------------------------------------------------------
// tb_box_table_point_lookup_core
// drives clear, append, query and unused-command items through the box table with random
// gaps and output stalls, predicts every result from a local copy of the
// table and margin, and compares status, hit_id and hit_count in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_box_table_point_lookup_core;
  import btpl_pkg::*;

  localparam int TableCap   = MaxBoxes;
  localparam int StallLimit = 20000;
  localparam int RandItems  = 555;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [22:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] cmd = '0;
  logic [15:0] box_id = '0;
  logic [7:0] box_level = '0;
  logic box_ok = 1'b0;
  logic signed [CoordW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  logic [1:0] status;
  logic [15:0] hit_id;
  logic [CntW-1:0] hit_count;

  box_table_point_lookup_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .box_id(box_id),
    .box_level(box_level), .box_ok(box_ok), .ax(ax), .ay(ay), .az(az),
    .bx(bx), .by(by), .bz(bz), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .hit_id(hit_id), .hit_count(hit_count)
  );

  always #5 clk = ~clk;

  // items waiting to be driven and results waiting to arrive
  btpl_item_t   pending_items[$];
  btpl_result_t awaited_results[$];

  // local copy of the table and margin
  logic [22:0]        margin_q;
  int                 box_count;
  logic [15:0]        tbl_id[TableCap];
  logic [7:0]         tbl_level[TableCap];
  logic signed [23:0] tbl_lo[TableCap][3];
  logic signed [23:0] tbl_hi[TableCap][3];
  logic [51:0]        tbl_diag[TableCap];

  int  fail_count = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  function automatic void add_item(btpl_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic logic [51:0] sq_extent(logic signed [23:0] hi, logic signed [23:0] lo);
    longint d;
    d = longint'(hi) - longint'(lo);
    if (d < 0) d = -d;
    return 52'(d * d);
  endfunction

  // apply one item to the local table and return its result
  function automatic btpl_result_t lookup_apply(btpl_item_t it);
    btpl_result_t r;
    logic signed [23:0] pt[3];
    bit found, inside_box;
    logic [7:0] bl;
    logic [51:0] bd;
    logic [15:0] bi;
    r = '0;
    found = 0; bl = 0; bd = 0; bi = 0;
    case (it.cmd)
      CMD_CLEAR: box_count = 0;
      CMD_APPEND: begin
        if (!it.box_ok) r.status = ST_REJECT;
        else if (box_count >= TableCap) r.status = ST_FULL;
        else begin
          tbl_lo[box_count] = '{it.ax, it.ay, it.az};
          tbl_hi[box_count] = '{it.bx, it.by, it.bz};
          tbl_id[box_count] = it.box_id;
          tbl_level[box_count] = it.box_level;
          tbl_diag[box_count] = sq_extent(it.bx, it.ax) + sq_extent(it.by, it.ay)
                              + sq_extent(it.bz, it.az);
          box_count++;
        end
      end
      CMD_QUERY: begin
        pt = '{it.ax, it.ay, it.az};
        for (int k = 0; k < box_count; k++) begin
          inside_box = 1;
          for (int a = 0; a < 3; a++) begin
            if (longint'(pt[a]) < longint'(tbl_lo[k][a]) - longint'(margin_q)) inside_box = 0;
            if (longint'(pt[a]) > longint'(tbl_hi[k][a]) + longint'(margin_q)) inside_box = 0;
          end
          if (inside_box) begin
            r.hit_count++;
            if (!found || tbl_level[k] > bl ||
                (tbl_level[k] == bl && tbl_diag[k] < bd) ||
                (tbl_level[k] == bl && tbl_diag[k] == bd && tbl_id[k] < bi)) begin
              found = 1; bl = tbl_level[k]; bd = tbl_diag[k]; bi = tbl_id[k];
            end
          end
        end
        if (found) r.hit_id = bi;
        else r.status = ST_MISS;
      end
      default: ;
    endcase
    return r;
  endfunction

  // driver: present the head item after a random gap, hold it while stalled
  always @(posedge clk) begin
    btpl_result_t pred;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = lookup_apply(pending_items.pop_front());
        awaited_results = {awaited_results, pred};
        send_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || pending_items.size() == 0) begin
          if (send_gap > 0) send_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid  <= 1'b1;
          cmd       <= pending_items[0].cmd;
          box_id    <= pending_items[0].box_id;
          box_level <= pending_items[0].box_level;
          box_ok    <= pending_items[0].box_ok;
          ax <= pending_items[0].ax; ay <= pending_items[0].ay;
          az <= pending_items[0].az; bx <= pending_items[0].bx;
          by <= pending_items[0].by; bz <= pending_items[0].bz;
        end
      end
    end
  end

  // monitor: random output stalls and in-order comparison
  always @(posedge clk) begin
    btpl_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: status %0d", status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, status);
            fail_count++;
          end
          if (hit_id !== want.hit_id) begin
            $error("hit_id expected %0d actual %0d", want.hit_id, hit_id);
            fail_count++;
          end
          if (hit_count !== want.hit_count) begin
            $error("hit_count expected %0d actual %0d", want.hit_count, hit_count);
            fail_count++;
          end
        end
        recv_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("tb_box_table_point_lookup_core: FAIL");
      $finish;
    end
  end

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic btpl_item_t make_box(logic [15:0] id, logic [7:0] lvl, bit ok,
                                          bit wide);
    btpl_item_t it;
    logic signed [23:0] c;
    it = '0;
    it.cmd = CMD_APPEND; it.box_id = id; it.box_level = lvl; it.box_ok = ok;
    if (wide) begin
      it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
      it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
    end else begin
      // small boxes near the origin so queries land inside several
      c = 24'($signed($urandom_range(0, 2000)) - 1000);
      it.ax = c; it.bx = c + 24'($urandom_range(0, 1500));
      c = 24'($signed($urandom_range(0, 2000)) - 1000);
      it.ay = c; it.by = c + 24'($urandom_range(0, 1500));
      c = 24'($signed($urandom_range(0, 2000)) - 1000);
      it.az = c; it.bz = c + 24'($urandom_range(0, 1500));
      if ($urandom_range(0, 15) == 0) it.bx = it.ax - 24'($urandom_range(1, 50));
    end
    return it;
  endfunction

  function automatic btpl_item_t make_query(bit wide);
    btpl_item_t it;
    it = '0;
    it.cmd = CMD_QUERY;
    it.box_id = 16'($urandom); it.box_level = 8'($urandom); it.box_ok = 1'($urandom);
    it.bx = 24'($urandom); it.by = 24'($urandom); it.bz = 24'($urandom);
    if (wide) begin
      it.ax = rand_coord(); it.ay = rand_coord(); it.az = rand_coord();
    end else begin
      it.ax = 24'($signed($urandom_range(0, 3000)) - 1000);
      it.ay = 24'($signed($urandom_range(0, 3000)) - 1000);
      it.az = 24'($signed($urandom_range(0, 3000)) - 1000);
    end
    return it;
  endfunction

  // wait for the block to drain, then write the margin
  task automatic set_margin(logic [22:0] m);
    while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (TableCap + 20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    margin_q = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    btpl_item_t it;
    logic [22:0] margins[4];
    margin_q = '0;
    box_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty query, extreme boxes, reject, inverted box, unused command, clear
    it = '0; it.cmd = CMD_QUERY; add_item(it);
    it = '0; it.cmd = CMD_APPEND; it.box_ok = 1; it.box_id = 16'hFFFF; it.box_level = 8'hFF;
    it.ax = -24'sh800000; it.ay = -24'sh800000; it.az = -24'sh800000;
    it.bx = 24'sh7FFFFF; it.by = 24'sh7FFFFF; it.bz = 24'sh7FFFFF;
    add_item(it);
    it.box_id = 16'h0000; add_item(it);
    it.box_ok = 0; add_item(it);
    add_item(make_box(16'h1234, 8'h00, 1, 0));
    it = '0; it.cmd = CMD_APPEND; it.box_ok = 1; it.box_id = 16'h5555; it.box_level = 8'h80;
    it.ax = 24'sd100; it.bx = 24'sd50; it.by = 24'sd10; it.bz = 24'sd10;
    add_item(it);
    it = '0; it.cmd = CMD_QUERY; it.ax = 24'sd75; it.ay = 24'sd5; it.az = 24'sd5;
    add_item(it);
    it.ax = 24'sh7FFFFF; it.ay = 24'sh7FFFFF; it.az = 24'sh7FFFFF; add_item(it);
    it.ax = -24'sh800000; it.ay = -24'sh800000; it.az = -24'sh800000; add_item(it);
    it = '1; it.cmd = CMD_NONE; add_item(it);
    it = '0; it.cmd = CMD_CLEAR; add_item(it);
    add_item(make_query(0));

    // margins: max closes the inverted gap, zero, and mid values
    margins = '{23'h7FFFFF, 23'd200, 23'd0, 23'($urandom)};
    set_margin(margins[0]);
    it = '0; it.cmd = CMD_APPEND; it.box_ok = 1; it.box_id = 16'h5555; it.box_level = 8'h80;
    it.ax = 24'sd100; it.bx = 24'sd50; add_item(it);
    add_item(make_query(1));
    it = '0; it.cmd = CMD_QUERY; it.ax = 24'sh7FFFFF; add_item(it);

    for (int ph = 1; ph < 4; ph++) begin
      if (ph > 1) set_margin(margins[ph - 1]);
      for (int n = 0; n < RandItems / 3; n++) begin
        case ($urandom_range(0, 19))
          0:        begin it = '0; it.cmd = CMD_CLEAR; it.box_id = 16'($urandom); end
          1:        begin it = make_box(16'($urandom), 8'($urandom), 1, 0); it.cmd = CMD_NONE; end
          2, 3:     it = make_box(16'($urandom), 8'($urandom), $urandom_range(0, 1), 1);
          4, 5:     it = make_query(1);
          6, 7, 8, 9, 10, 11:
                    it = make_box(16'($urandom_range(0, 15)), 8'($urandom_range(0, 3)),
                                  $urandom_range(0, 9) != 0, 0);
          default:  it = make_query(0);
        endcase
        add_item(it);
      end
    end
    set_margin(margins[3]);

    // a rejected box and a few queries on the table under the last margin
    add_item(make_box(16'hBEEF, 8'h01, 0, 0));
    for (int n = 0; n < 8; n++) add_item(make_query(0));

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TableCap + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_box_table_point_lookup_core: PASS");
    end else begin
      $display("tb_box_table_point_lookup_core: FAIL");
    end
    $finish;
  end

endmodule
